/* hdl/esa_pkg.sv */
// ============================================================================
// esa_pkg: shared types and constants of the evaluation stack ALU
// Word widths, operation and status codes, controller states, and the
// command and status groups that join the controller and the datapath.
// ============================================================================
`default_nettype none

package esa_pkg;

    localparam int WORD_W          = 32;
    localparam int OP_W            = 3;
    localparam int STAT_W          = 2;
    localparam int HELD_W          = 5;
    localparam int STEP_W          = $clog2(WORD_W);
    localparam int STACK_DEPTH_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_DEC  = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4,
        OP_MPY  = 3'd5,
        OP_DIV  = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FEW     = 2'd1,
        ST_FULL    = 2'd2,
        ST_DIVZERO = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_Y,
        S_READ_X,
        S_EXEC,
        S_WRITE,
        S_FINISH
    } state_t;

    // stack address relative to the fill count
    typedef enum logic [1:0] {
        ADR_FREE,
        ADR_TOP,
        ADR_SECOND
    } adr_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_PUSH,
        RES_RDATA,
        RES_ALU
    } res_src_t;

    typedef enum logic [1:0] {
        WD_PUSH,
        WD_DEC,
        WD_ALU
    } wd_sel_t;

    typedef struct packed {
        logic     latch_req;
        logic     rd_en;
        adr_sel_t rd_sel;
        logic     mem_wr;
        adr_sel_t wr_sel;
        wd_sel_t  wd_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     load_y;
        logic     load_x;
        logic     alu_start;
        logic     set_res;
        res_src_t res_src;
        stat_t    res_stat;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic few;
        logic full;
        logic y_zero;
        logic alu_last;
    } sts_t;

endpackage

`default_nettype wire

/* hdl/esa_ctrl.sv */
// ============================================================================
// esa_ctrl: request sequencer of the evaluation stack ALU
// Walks each request through decode, operand reads, the iterative unit and
// write-back, and drives the input and output handshakes.
// ============================================================================
`default_nettype none

module esa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire esa_pkg::sts_t sts,
    output esa_pkg::cmd_t      cmd
);

    esa_pkg::state_t state_reg;
    esa_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= esa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            esa_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = esa_pkg::S_DECODE;
                end
            end

            esa_pkg::S_DECODE:
            begin
                unique case (sts.op) inside
                    esa_pkg::OP_PUSH:
                    begin
                        cmd.set_res = 1'b1;
                        if (sts.full)
                        begin
                            cmd.res_src  = esa_pkg::RES_ZERO;
                            cmd.res_stat = esa_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.mem_wr   = 1'b1;
                            cmd.wr_sel   = esa_pkg::ADR_FREE;
                            cmd.wd_sel   = esa_pkg::WD_PUSH;
                            cmd.cnt_inc  = 1'b1;
                            cmd.res_src  = esa_pkg::RES_PUSH;
                            cmd.res_stat = esa_pkg::ST_OK;
                        end
                        state_next = esa_pkg::S_FINISH;
                    end
                    esa_pkg::OP_POP, esa_pkg::OP_DEC:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_res  = 1'b1;
                            cmd.res_src  = esa_pkg::RES_ZERO;
                            cmd.res_stat = esa_pkg::ST_FEW;
                            state_next   = esa_pkg::S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = esa_pkg::ADR_TOP;
                            state_next = esa_pkg::S_READ_Y;
                        end
                    end
                    esa_pkg::OP_ADD, esa_pkg::OP_SUB, esa_pkg::OP_MPY, esa_pkg::OP_DIV:
                    begin
                        if (sts.few)
                        begin
                            cmd.set_res  = 1'b1;
                            cmd.res_src  = esa_pkg::RES_ZERO;
                            cmd.res_stat = esa_pkg::ST_FEW;
                            state_next   = esa_pkg::S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = esa_pkg::ADR_TOP;
                            state_next = esa_pkg::S_READ_Y;
                        end
                    end
                    default:
                    begin
                        // unused code: no operation
                        cmd.set_res  = 1'b1;
                        cmd.res_src  = esa_pkg::RES_ZERO;
                        cmd.res_stat = esa_pkg::ST_OK;
                        state_next   = esa_pkg::S_FINISH;
                    end
                endcase
            end

            esa_pkg::S_READ_Y:
            begin
                cmd.load_y = 1'b1;
                unique case (sts.op) inside
                    esa_pkg::OP_POP:
                    begin
                        cmd.cnt_dec  = 1'b1;
                        cmd.set_res  = 1'b1;
                        cmd.res_src  = esa_pkg::RES_RDATA;
                        cmd.res_stat = esa_pkg::ST_OK;
                        state_next   = esa_pkg::S_FINISH;
                    end
                    esa_pkg::OP_DEC:
                    begin
                        cmd.mem_wr   = 1'b1;
                        cmd.wr_sel   = esa_pkg::ADR_TOP;
                        cmd.wd_sel   = esa_pkg::WD_DEC;
                        cmd.set_res  = 1'b1;
                        cmd.res_src  = esa_pkg::RES_RDATA;
                        cmd.res_stat = esa_pkg::ST_OK;
                        state_next   = esa_pkg::S_FINISH;
                    end
                    default:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = esa_pkg::ADR_SECOND;
                        state_next = esa_pkg::S_READ_X;
                    end
                endcase
            end

            esa_pkg::S_READ_X:
            begin
                cmd.load_x = 1'b1;
                unique case (sts.op) inside
                    esa_pkg::OP_DIV:
                    begin
                        if (sts.y_zero)
                        begin
                            cmd.set_res  = 1'b1;
                            cmd.res_src  = esa_pkg::RES_ZERO;
                            cmd.res_stat = esa_pkg::ST_DIVZERO;
                            state_next   = esa_pkg::S_FINISH;
                        end
                        else
                        begin
                            cmd.alu_start = 1'b1;
                            state_next    = esa_pkg::S_EXEC;
                        end
                    end
                    esa_pkg::OP_MPY:
                    begin
                        cmd.alu_start = 1'b1;
                        state_next    = esa_pkg::S_EXEC;
                    end
                    default:
                    begin
                        state_next = esa_pkg::S_WRITE;
                    end
                endcase
            end

            esa_pkg::S_EXEC:
            begin
                if (sts.alu_last)
                begin
                    state_next = esa_pkg::S_WRITE;
                end
            end

            esa_pkg::S_WRITE:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_sel   = esa_pkg::ADR_SECOND;
                cmd.wd_sel   = esa_pkg::WD_ALU;
                cmd.cnt_dec  = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_src  = esa_pkg::RES_ALU;
                cmd.res_stat = esa_pkg::ST_OK;
                state_next   = esa_pkg::S_FINISH;
            end

            esa_pkg::S_FINISH:
            begin
                // hand over once the output register is empty or being taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = esa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = esa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/esa_dp.sv */
// ============================================================================
// esa_dp: datapath of the evaluation stack ALU
// Stack memory and fill count, operand registers, a shared shift-add
// multiplier and restoring divider, and the output word register.
// ============================================================================
`default_nettype none

module esa_dp #(
    parameter int STACK_DEPTH = esa_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire esa_pkg::cmd_t                       cmd,
    output esa_pkg::sts_t                            sts,
    input  wire logic        [esa_pkg::OP_W-1:0]     req_type,
    input  wire logic signed [esa_pkg::WORD_W-1:0]   push_value,
    output logic signed      [esa_pkg::WORD_W-1:0]   result_value,
    output logic             [esa_pkg::STAT_W-1:0]   status,
    output logic             [esa_pkg::HELD_W-1:0]   entries_held
);

    localparam int W      = esa_pkg::WORD_W;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [W-1:0]           mem [STACK_DEPTH];

    esa_pkg::op_t           op_reg;
    logic [W-1:0]           pv_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [W-1:0]           rdata_reg;
    logic [W-1:0]           y_reg;
    logic [W-1:0]           x_reg;
    logic [W-1:0]           a_reg;
    logic [W-1:0]           b_reg;
    logic [W-1:0]           m_reg;
    logic                   neg_reg;
    logic                   busy_reg;
    logic [esa_pkg::STEP_W-1:0] step_reg;
    logic [W-1:0]           res_reg;
    esa_pkg::stat_t         stat_reg;
    logic [W-1:0]           out_res_reg;
    esa_pkg::stat_t         out_stat_reg;
    logic [esa_pkg::HELD_W-1:0] out_held_reg;

    logic [ADDR_W-1:0]      adr_free;
    logic [ADDR_W-1:0]      adr_top;
    logic [ADDR_W-1:0]      adr_second;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [W-1:0]           wr_data;
    logic [W-1:0]           alu_res;
    logic [W-1:0]           res_val;
    logic [W:0]             div_trial;
    logic                   div_ge;
    logic                   is_div;

    assign adr_free   = ADDR_W'(cnt_reg);
    assign adr_top    = ADDR_W'(cnt_reg - CNT_W'(1));
    assign adr_second = ADDR_W'(cnt_reg - CNT_W'(2));
    assign is_div     = (op_reg == esa_pkg::OP_DIV);

    always_comb
    begin
        case (cmd.rd_sel)
            esa_pkg::ADR_SECOND: rd_addr = adr_second;
            default:             rd_addr = adr_top;
        endcase
        case (cmd.wr_sel)
            esa_pkg::ADR_FREE:   wr_addr = adr_free;
            esa_pkg::ADR_SECOND: wr_addr = adr_second;
            default:             wr_addr = adr_top;
        endcase
        case (cmd.wd_sel)
            esa_pkg::WD_PUSH: wr_data = pv_reg;
            esa_pkg::WD_DEC:  wr_data = rdata_reg - W'(1);
            default:          wr_data = alu_res;
        endcase
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // request and operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            op_reg <= esa_pkg::op_t'(req_type);
            pv_reg <= push_value;
        end
        if (cmd.load_y)
        begin
            y_reg <= rdata_reg;
        end
        if (cmd.load_x)
        begin
            x_reg <= rdata_reg;
        end
    end

    // one restoring division step: shift in the next dividend bit, try subtract
    assign div_trial = {a_reg, b_reg[W-1]};
    assign div_ge    = (div_trial >= {1'b0, m_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.alu_start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + esa_pkg::STEP_W'(1);
            if (sts.alu_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alu_start)
        begin
            a_reg <= '0;
            if (is_div)
            begin
                // divide magnitudes, fix the sign at the end
                b_reg   <= rdata_reg[W-1] ? (W'(0) - rdata_reg) : rdata_reg;
                m_reg   <= y_reg[W-1] ? (W'(0) - y_reg) : y_reg;
                neg_reg <= rdata_reg[W-1] ^ y_reg[W-1];
            end
            else
            begin
                b_reg   <= y_reg;
                m_reg   <= rdata_reg;
                neg_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (is_div)
            begin
                a_reg <= div_ge ? W'(div_trial - {1'b0, m_reg}) : W'(div_trial);
                b_reg <= {b_reg[W-2:0], div_ge};
            end
            else
            begin
                a_reg <= a_reg + (b_reg[0] ? m_reg : W'(0));
                b_reg <= {1'b0, b_reg[W-1:1]};
                m_reg <= {m_reg[W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        case (op_reg)
            esa_pkg::OP_ADD: alu_res = x_reg + y_reg;
            esa_pkg::OP_SUB: alu_res = x_reg - y_reg;
            esa_pkg::OP_MPY: alu_res = a_reg;
            esa_pkg::OP_DIV: alu_res = neg_reg ? (W'(0) - b_reg) : b_reg;
            default:         alu_res = '0;
        endcase
        case (cmd.res_src)
            esa_pkg::RES_PUSH:  res_val = pv_reg;
            esa_pkg::RES_RDATA: res_val = rdata_reg;
            esa_pkg::RES_ALU:   res_val = alu_res;
            default:            res_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            res_reg  <= res_val;
            stat_reg <= cmd.res_stat;
        end
        if (cmd.load_out)
        begin
            out_res_reg  <= res_reg;
            out_stat_reg <= stat_reg;
            out_held_reg <= esa_pkg::HELD_W'(cnt_reg);
        end
    end

    assign sts.op       = op_reg;
    assign sts.empty    = (cnt_reg == '0);
    assign sts.few      = (cnt_reg < CNT_W'(2));
    assign sts.full     = (cnt_reg >= CNT_W'(STACK_DEPTH));
    assign sts.y_zero   = (y_reg == '0);
    assign sts.alu_last = busy_reg && (step_reg == esa_pkg::STEP_W'(W - 1));

    assign result_value = out_res_reg;
    assign status       = out_stat_reg;
    assign entries_held = out_held_reg;

endmodule

`default_nettype wire

/* hdl/evaluation_stack_alu.sv */
// ============================================================================
// evaluation_stack_alu: bounded evaluation stack with an integer ALU
// Push, pop, decrement and the four arithmetic operations on a stack of
// signed 32-bit words, one result word for every request word.
// ============================================================================
// The block takes one request word at a time and returns exactly one result
// word for it. Push, and any request turned away at decode (empty stack, too
// few operands, full stack, unused code), go from decode straight to the
// result word; pop and dec first read the top entry; add and sub read both
// operands and write back; a zero divisor is caught once both are read; and
// mpy and div run one bit per cycle through a shared shift-add /
// restoring-divide unit before the write-back. Every operand comes from the
// single registered read port of the stack memory, so the top and the entry
// below it are fetched one after the other. The next request is taken in the
// cycle right after the result word is loaded. in_stall stays high from the
// cycle after an accept until the result word sits in the output register;
// that register holds the word while out_stall is high, and a new request is
// taken meanwhile. Requests that cannot be carried out (empty stack, too few
// operands, full stack, zero divisor) leave the stack alone and report the
// reason in status with result_value zero. entries_held gives the fill count
// after the request, modulo 32. Stack entries hold no reset value; only
// entries below the fill count are ever read.
// ============================================================================
`default_nettype none

module evaluation_stack_alu #(
    parameter int STACK_DEPTH = esa_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic        [esa_pkg::OP_W-1:0]   req_type,
    input  wire logic signed [esa_pkg::WORD_W-1:0] push_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed      [esa_pkg::WORD_W-1:0] result_value,
    output logic             [esa_pkg::STAT_W-1:0] status,
    output logic             [esa_pkg::HELD_W-1:0] entries_held
);

    // command group from the sequencer, condition group back from the datapath
    esa_pkg::cmd_t cmd;
    esa_pkg::sts_t sts;

    // sequencer: owns both handshakes and steps each request word
    esa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: stack memory, count, iterative unit and the result word
    esa_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .push_value   (push_value),
        .result_value (result_value),
        .status       (status),
        .entries_held (entries_held)
    );

endmodule

`default_nettype wire

/* hdl/esa_checker.sv */
// ============================================================================
// esa_checker: port-level checks of the evaluation stack ALU
// Watches the handshakes and result words and flags what cannot happen.
// ============================================================================
`default_nettype none

module esa_checker #(
    parameter int STACK_DEPTH = esa_pkg::STACK_DEPTH_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic signed [esa_pkg::WORD_W-1:0] result_value,
    input wire logic        [esa_pkg::STAT_W-1:0] status,
    input wire logic        [esa_pkg::HELD_W-1:0] entries_held
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value)
            && $stable(status) && $stable(entries_held))
        else $error("result word changed while stalled");

    // one request at a time: stall right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in progress");

    a_few_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == esa_pkg::ST_FEW) && (STACK_DEPTH < 32)
            |-> (entries_held < 5'd2))
        else $error("too-few status with two or more entries held");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == esa_pkg::ST_FULL) && (STACK_DEPTH < 32)
            |-> (32'(entries_held) == STACK_DEPTH))
        else $error("full status while the stack is not full");

endmodule

bind evaluation_stack_alu esa_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_esa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .status       (status),
    .entries_held (entries_held)
);

`default_nettype wire
